/* src/imu_node_link_controller_defines.svh */
// Assertion macros used by the checker file
`ifndef IMU_NODE_LINK_CONTROLLER_DEFINES_SVH
`define IMU_NODE_LINK_CONTROLLER_DEFINES_SVH

// Clocked assertion, switched off while reset is high
`define NLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define NLC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/nlc_pkg.sv */
package nlc_pkg;

  // Input event codes
  localparam logic [2:0] OP_CMD    = 3'd0;
  localparam logic [2:0] OP_SEND   = 3'd1;
  localparam logic [2:0] OP_INIT   = 3'd2;
  localparam logic [2:0] OP_SAMPLE = 3'd3;
  localparam logic [2:0] OP_POLL   = 3'd4;

  // Command codes
  localparam logic [7:0] CODE_SET_RATE    = 8'd1;
  localparam logic [7:0] CODE_GO_STREAM   = 8'd2;
  localparam logic [7:0] CODE_HALT_STREAM = 8'd3;
  localparam logic [7:0] CODE_RECALIBRATE = 8'd4;
  localparam logic [7:0] CODE_TIME_SYNC   = 8'd5;
  localparam logic [7:0] CODE_LINK_UP     = 8'd6;
  localparam logic [7:0] CODE_LINK_DOWN   = 8'd7;

  // Result kinds
  localparam logic [2:0] KIND_STATUS = 3'd0;
  localparam logic [2:0] KIND_RECORD = 3'd1;
  localparam logic [2:0] KIND_BEACON = 3'd2;
  localparam logic [2:0] KIND_RATE   = 3'd3;
  localparam logic [2:0] KIND_INIT   = 3'd4;

  // Node modes
  localparam logic [1:0] MODE_IDLE      = 2'd0;
  localparam logic [1:0] MODE_CONNECTED = 2'd1;
  localparam logic [1:0] MODE_STREAMING = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_NODE_NUMBER   = 3'd0;
  localparam logic [2:0] REG_IDLE_PERIOD   = 3'd1;
  localparam logic [2:0] REG_STREAM_PERIOD = 3'd2;
  localparam logic [2:0] REG_FAIL_LIMIT    = 3'd3;
  localparam logic [2:0] REG_RATE_FLOOR    = 3'd4;
  localparam logic [2:0] REG_RATE_CEILING  = 3'd5;

  // Reset values
  localparam logic [31:0] IDLE_PERIOD_RST   = 32'd1000000;
  localparam logic [31:0] STREAM_PERIOD_RST = 32'd5000000;
  localparam logic [7:0]  FAIL_LIMIT_RST    = 8'd20;
  localparam logic [7:0]  RATE_FLOOR_RST    = 8'd10;
  localparam logic [7:0]  RATE_CEILING_RST  = 8'd200;
  localparam logic [7:0]  FAIL_COUNT_MAX    = 8'd255;
  localparam logic [2:0]  REPORT_NEEDED     = 3'b111;
  localparam logic signed [15:0] Q_ONE      = 16'sd16384;
  localparam int          Q_SHIFT           = 14;

  // Depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef logic signed [15:0] q14_t;

  typedef struct packed {
    q14_t i;
    q14_t j;
    q14_t k;
    q14_t r;
  } quat_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  cmd_code;
    logic [7:0]  cmd_param;
    logic [31:0] cmd_arg;
    logic [31:0] local_time;
    logic        ok_flag;
    q14_t        sample_i;
    q14_t        sample_j;
    q14_t        sample_k;
    q14_t        sample_r;
    logic [7:0]  report_mask;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  node_state;
    logic [7:0]  node_tag;
    logic [7:0]  rate_hz;
    logic [31:0] stamp;
    q14_t        out_i;
    q14_t        out_j;
    q14_t        out_k;
    q14_t        out_r;
    logic [7:0]  calib_mask;
    logic        last;
  } out_item_t;

  // One classified event: first result, optional trailing beacon
  typedef struct packed {
    logic [2:0]  kind;
    logic        beacon_after;
    logic [1:0]  node_state;
    logic [7:0]  node_tag;
    logic [7:0]  rate_hz;
    logic [31:0] stamp;
    quat_t       sample;
    quat_t       refq;
    logic        tare_on;
    logic [7:0]  calib_mask;
  } job_t;

endpackage

/* src/imu_node_link_controller.sv */
// Sensor-node link controller. One input transfer is taken per clock while the
// job queue (QueueDepth entries) has room; each event gives one result, or two
// for a sample that also triggers a heartbeat beacon, and the output port sends
// one result per cycle while out_ready is high, so a two-result event holds the
// back end until both results are taken. The event is classified and queued at
// its input transfer edge; the job then passes from the queue to the multiply
// stage (sixteen 16x16 products in parallel) and from there to the sum, floor and
// saturate stage, which fills the output register. Configuration writes are
// registered and apply to events accepted after the write.
module imu_node_link_controller #(
  parameter int QueueDepth = nlc_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  nlc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output nlc_pkg::out_item_t out_data
);
  import nlc_pkg::*;

  job_t front_job;
  job_t queue_job;
  logic accept, queue_full, queue_valid, queue_pop;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  nlc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (in_data),
    .job       (front_job)
  );

  nlc_queue #(.Depth(QueueDepth)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_job  (front_job),
    .full      (queue_full),
    .pop_valid (queue_valid),
    .pop       (queue_pop),
    .pop_job   (queue_job)
  );

  logic back_ready;
  assign queue_pop = queue_valid && back_ready;

  nlc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (queue_valid),
    .job_ready (back_ready),
    .job       (queue_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* src/nlc_front.sv */
module nlc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  input  logic             accept,
  input  nlc_pkg::in_item_t item,
  output nlc_pkg::job_t    job
);
  import nlc_pkg::*;

  logic [7:0]  node_number;
  logic [31:0] idle_period;
  logic [31:0] stream_period;
  logic [7:0]  fail_limit;
  logic [7:0]  rate_floor;
  logic [7:0]  rate_ceiling;

  logic [1:0]  mode, mode_next;
  logic [31:0] clock_offset, clock_offset_next;
  logic [7:0]  fail_count, fail_count_next;
  logic        tare_pending, tare_pending_next;
  logic        init_pending, init_pending_next;
  quat_t       refq, refq_next;
  logic        ref_valid, ref_valid_next;
  logic [31:0] last_beacon, last_beacon_next;

  logic [7:0]  fail_inc;
  logic [31:0] since_beacon;
  quat_t       sample;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_number   <= '0;
      idle_period   <= IDLE_PERIOD_RST;
      stream_period <= STREAM_PERIOD_RST;
      fail_limit    <= FAIL_LIMIT_RST;
      rate_floor    <= RATE_FLOOR_RST;
      rate_ceiling  <= RATE_CEILING_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NODE_NUMBER:   node_number   <= cfg_data[7:0];
        REG_IDLE_PERIOD:   idle_period   <= cfg_data;
        REG_STREAM_PERIOD: stream_period <= cfg_data;
        REG_FAIL_LIMIT:    fail_limit    <= cfg_data[7:0];
        REG_RATE_FLOOR:    rate_floor    <= cfg_data[7:0];
        REG_RATE_CEILING:  rate_ceiling  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Node state, advanced on each accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      clock_offset <= '0;
      fail_count   <= '0;
      tare_pending <= 1'b0;
      init_pending <= 1'b0;
      refq         <= '{i: '0, j: '0, k: '0, r: Q_ONE};
      ref_valid    <= 1'b0;
      last_beacon  <= '0;
    end else if (accept) begin
      mode         <= mode_next;
      clock_offset <= clock_offset_next;
      fail_count   <= fail_count_next;
      tare_pending <= tare_pending_next;
      init_pending <= init_pending_next;
      refq         <= refq_next;
      ref_valid    <= ref_valid_next;
      last_beacon  <= last_beacon_next;
    end
  end

  // Classify the event and work out the next state
  always_comb begin
    mode_next         = mode;
    clock_offset_next = clock_offset;
    fail_count_next   = fail_count;
    tare_pending_next = tare_pending;
    init_pending_next = init_pending;
    refq_next         = refq;
    ref_valid_next    = ref_valid;
    last_beacon_next  = last_beacon;
    fail_inc          = (fail_count < FAIL_COUNT_MAX) ? fail_count + 8'd1 : fail_count;
    since_beacon      = item.local_time - last_beacon;
    sample            = '{i: item.sample_i, j: item.sample_j,
                          k: item.sample_k, r: item.sample_r};

    job              = '0;
    job.kind         = KIND_STATUS;

    case (item.op)
      OP_CMD: begin
        if (item.ok_flag) begin
          case (item.cmd_code)
            CODE_SET_RATE: begin
              if (mode != MODE_IDLE && item.cmd_param >= rate_floor &&
                  item.cmd_param <= rate_ceiling) begin
                job.kind    = KIND_RATE;
                job.rate_hz = item.cmd_param;
              end
            end
            CODE_GO_STREAM: begin
              if (mode != MODE_IDLE) mode_next = MODE_STREAMING;
            end
            CODE_HALT_STREAM: begin
              if (mode == MODE_STREAMING) mode_next = MODE_CONNECTED;
            end
            CODE_RECALIBRATE: begin
              if (mode == MODE_CONNECTED || mode == MODE_STREAMING) begin
                tare_pending_next = 1'b1;
              end else begin
                init_pending_next = 1'b1;
                job.kind          = KIND_INIT;
              end
            end
            CODE_TIME_SYNC: begin
              clock_offset_next = item.cmd_arg - item.local_time;
            end
            CODE_LINK_UP: begin
              if (mode == MODE_IDLE) begin
                init_pending_next = 1'b1;
                job.kind          = KIND_INIT;
              end
            end
            CODE_LINK_DOWN: begin
              mode_next = MODE_IDLE;
            end
            default: ;
          endcase
        end
      end
      OP_SEND: begin
        if (item.ok_flag) begin
          fail_count_next = '0;
        end else begin
          fail_count_next = fail_inc;
          if (fail_inc >= fail_limit && mode != MODE_IDLE) begin
            mode_next       = MODE_IDLE;
            fail_count_next = '0;
          end
        end
      end
      OP_INIT: begin
        if (init_pending) begin
          init_pending_next = 1'b0;
          if (item.ok_flag) begin
            mode_next        = MODE_CONNECTED;
            last_beacon_next = item.local_time;
            job.kind         = KIND_BEACON;
          end
        end
      end
      OP_SAMPLE: begin
        if (mode == MODE_STREAMING && item.report_mask[2:0] == REPORT_NEEDED) begin
          if (tare_pending) begin
            tare_pending_next = 1'b0;
            refq_next         = sample;
            ref_valid_next    = 1'b1;
          end
          job.kind       = KIND_RECORD;
          job.sample     = sample;
          job.refq       = refq_next;
          job.tare_on    = ref_valid_next;
          job.calib_mask = item.report_mask;
          if (since_beacon >= stream_period) begin
            last_beacon_next = item.local_time;
            job.beacon_after = 1'b1;
          end
        end
      end
      OP_POLL: begin
        if (mode == MODE_IDLE && since_beacon >= idle_period) begin
          last_beacon_next = item.local_time;
          job.kind         = KIND_BEACON;
        end
      end
      default: ;
    endcase

    job.node_state = mode_next;
    job.node_tag   = node_number;
    job.stamp      = item.local_time + clock_offset_next;
  end

endmodule

/* src/nlc_queue.sv */
module nlc_queue #(
  parameter int Depth = nlc_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  nlc_pkg::job_t push_job,
  output logic          full,
  output logic          pop_valid,
  input  logic          pop,
  output nlc_pkg::job_t pop_job
);
  import nlc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full      = (count == CntW'(Depth));
  assign pop_valid = (count != '0);
  assign pop_job   = slots[rd_ptr];

  // Store incoming jobs
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/nlc_back.sv */
module nlc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_ready,
  input  nlc_pkg::job_t      job,
  output logic               out_valid,
  input  logic               out_ready,
  output nlc_pkg::out_item_t out_data
);
  import nlc_pkg::*;

  // Stage one: job and the sixteen partial products
  logic               s1_valid;
  job_t               s1_job;
  logic signed [31:0] prod [16];

  // Stage two: finished job in the output register
  logic               s2_valid;
  job_t               s2_job;
  quat_t              s2_quat;
  logic               phase;

  logic               s1_free, s2_free, done;
  logic signed [34:0] sum_i, sum_j, sum_k, sum_r;
  quat_t              tared;

  function automatic q14_t q14_sat(input logic signed [34:0] s);
    logic signed [34:0] f;
    f = s >>> Q_SHIFT;
    if (f > 35'sd32767)       q14_sat = 16'sh7fff;
    else if (f < -35'sd32768) q14_sat = 16'sh8000;
    else                      q14_sat = f[15:0];
  endfunction

  assign done      = out_valid && out_ready && (phase || !s2_job.beacon_after);
  assign s2_free   = !s2_valid || done;
  assign s1_free   = !s1_valid || s2_free;
  assign job_ready = s1_free;

  // Multiply reference conjugate by sample, one product per term
  always_ff @(posedge clk) begin
    if (s1_free && job_valid) begin
      s1_job   <= job;
      prod[0]  <= job.refq.r * job.sample.r;
      prod[1]  <= job.refq.i * job.sample.i;
      prod[2]  <= job.refq.j * job.sample.j;
      prod[3]  <= job.refq.k * job.sample.k;
      prod[4]  <= job.refq.r * job.sample.i;
      prod[5]  <= job.refq.i * job.sample.r;
      prod[6]  <= job.refq.j * job.sample.k;
      prod[7]  <= job.refq.k * job.sample.j;
      prod[8]  <= job.refq.r * job.sample.j;
      prod[9]  <= job.refq.i * job.sample.k;
      prod[10] <= job.refq.j * job.sample.r;
      prod[11] <= job.refq.k * job.sample.i;
      prod[12] <= job.refq.r * job.sample.k;
      prod[13] <= job.refq.i * job.sample.j;
      prod[14] <= job.refq.j * job.sample.i;
      prod[15] <= job.refq.k * job.sample.r;
    end
  end

  // Sum, floor and saturate each component, or pass the sample through when tare is off
  always_comb begin
    sum_r = 35'(prod[0]) + 35'(prod[1]) + 35'(prod[2]) + 35'(prod[3]);
    sum_i = 35'(prod[4]) - 35'(prod[5]) - 35'(prod[6]) + 35'(prod[7]);
    sum_j = 35'(prod[8]) + 35'(prod[9]) - 35'(prod[10]) - 35'(prod[11]);
    sum_k = 35'(prod[12]) - 35'(prod[13]) + 35'(prod[14]) - 35'(prod[15]);
    if (s1_job.tare_on) begin
      tared = '{i: q14_sat(sum_i), j: q14_sat(sum_j),
                k: q14_sat(sum_k), r: q14_sat(sum_r)};
    end else begin
      tared = s1_job.sample;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      s2_job  <= s1_job;
      s2_quat <= tared;
    end
  end

  // Pipeline valid flags and result phase
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      phase    <= 1'b0;
    end else begin
      if (s1_free) s1_valid <= job_valid;
      if (s2_free) s2_valid <= s1_valid;
      if (done) begin
        phase <= 1'b0;
      end else if (out_valid && out_ready) begin
        phase <= 1'b1;
      end
    end
  end

  // Drive the result: first the main result, then a trailing beacon if one is due
  always_comb begin
    out_valid           = s2_valid;
    out_data            = '0;
    out_data.node_state = s2_job.node_state;
    out_data.node_tag   = s2_job.node_tag;
    out_data.stamp      = s2_job.stamp;
    if (phase) begin
      out_data.kind = KIND_BEACON;
      out_data.last = 1'b1;
    end else begin
      out_data.kind       = s2_job.kind;
      out_data.rate_hz    = s2_job.rate_hz;
      out_data.out_i      = s2_quat.i;
      out_data.out_j      = s2_quat.j;
      out_data.out_k      = s2_quat.k;
      out_data.out_r      = s2_quat.r;
      out_data.calib_mask = s2_job.calib_mask;
      out_data.last       = !s2_job.beacon_after;
    end
  end

endmodule

/* src/nlc_checker.sv */
`include "imu_node_link_controller_defines.svh"

module nlc_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input nlc_pkg::out_item_t out_data
);
  import nlc_pkg::*;

  // Hold a stalled result
  `NLC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result dropped or changed while stalled")

  // Nothing leaves straight after reset
  `NLC_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid, "result shown after reset")

  // Records only come out while streaming
  `NLC_ASSERT(a_record_mode, out_valid && out_data.kind == KIND_RECORD |-> out_data.node_state == MODE_STREAMING, "record outside streaming")

  // Rate requests only outside idle
  `NLC_ASSERT(a_rate_mode, out_valid && out_data.kind == KIND_RATE |-> out_data.node_state != MODE_IDLE, "rate request while idle")

  // Init requests only while idle
  `NLC_ASSERT(a_init_mode, out_valid && out_data.kind == KIND_INIT |-> out_data.node_state == MODE_IDLE, "init request outside idle")

endmodule

bind imu_node_link_controller nlc_checker u_nlc_checker (.*);
